>>> rtl/cct_pkg.sv
// shared types, constants and request codes of the compact target codec
package cct_pkg;

  // compact word layout
  localparam logic [23:0] MANT_MASK = 24'hFF_FFFF;
  localparam logic [23:0] SIGN_BIT  = 24'h80_0000;
  localparam int unsigned POS_CAP   = 29;
  localparam int unsigned EXP_SHIFT = 24;

  // widths of the stream words
  localparam int unsigned IN_DATA_W  = 544;
  localparam int unsigned OUT_DATA_W = 296;

  // request codes
  localparam logic [1:0] REQ_EXPAND   = 2'd0;
  localparam logic [1:0] REQ_COMPRESS = 2'd1;
  localparam logic [1:0] REQ_COMPARE  = 2'd2;

  // one request as held in the input register
  typedef struct packed {
    logic [1:0]   req_type;
    logic [31:0]  compact_in;
    logic [255:0] target;
    logic [255:0] hash;
  } req_t;

  // one result as held in the output register
  typedef struct packed {
    logic         meets;
    logic [255:0] expanded;
    logic [31:0]  compact_out;
  } res_t;

endpackage

>>> rtl/compact_target_codec_core.sv
// top level of the compact target codec with input and result registers
//
// Stream unit for compact difficulty words. Each input word on in_* carries
// a request whose kind is in in_tuser: expand a compact word into a 256-bit
// target, compress a target into a compact word, or test a hash against a
// target. Every input word yields exactly one result word on out_*; result
// fields that the request does not produce are zero.
// A word accepted on in_* is captured in the input register; its result
// moves into the result register once that register is free, and is then
// shown on out_tvalid. Throughput: one word per cycle while out_tready
// stays high; the byte shifter, the byte priority encoder and the 256-bit
// comparator all sit in the single stage between the two registers.
// Reset (rst_n low, synchronous) empties both registers; no other state.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more word, after which in_tready drops.
module compact_target_codec_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // compact_in, target_w0..w3, hash_w0..w3
  input  logic [cct_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // compact_out, expanded_w0..w3, meets, zero fill
  output logic [cct_pkg::OUT_DATA_W-1:0] out_tdata
);
  import cct_pkg::*;

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r, s1_req_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;
  logic out_adv, s1_adv;

  logic [255:0] exp_target;
  logic [31:0]  comp_word;
  logic         cmp_meets;

  // stage handshake
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;

  // input register next values
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_req_nxt   = s1_req_r;
    if (s1_adv) begin
      s1_valid_nxt        = in_tvalid;
      s1_req_nxt.req_type = in_tuser;
      s1_req_nxt.compact_in = in_tdata[31:0];
      s1_req_nxt.target   = in_tdata[287:32];
      s1_req_nxt.hash     = in_tdata[543:288];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_req_r <= s1_req_nxt;
  end

  // operation units
  cct_expand u_expand (
    .compact_in (s1_req_r.compact_in),
    .expanded   (exp_target)
  );

  cct_compress u_compress (
    .target      (s1_req_r.target),
    .compact_out (comp_word)
  );

  cct_compare u_compare (
    .hash   (s1_req_r.hash),
    .target (s1_req_r.target),
    .meets  (cmp_meets)
  );

  // result selection into the result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
      out_res_nxt   = '0;
      case (s1_req_r.req_type)
        REQ_EXPAND:   out_res_nxt.expanded    = exp_target;
        REQ_COMPRESS: out_res_nxt.compact_out = comp_word;
        REQ_COMPARE:  out_res_nxt.meets       = cmp_meets;
        default:      out_res_nxt             = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.meets, out_res_r.expanded, out_res_r.compact_out};

`ifndef SYNTHESIS
  // an accepted word lands in the input register
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted word not captured");

  // a held word is not lost while the result register is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_adv) |=> (s1_valid_r && $stable(s1_req_r)))
    else $error("input register word lost under stall");

  // a word in the input register moves on when the output frees up
  a_s1_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_adv) |=> out_valid_r)
    else $error("word did not reach the result register");

  // compressed exponent never exceeds 33
  a_comp_expo: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_req_r.req_type == REQ_COMPRESS) |-> (comp_word[31:24] <= 8'd33))
    else $error("compressed exponent out of range");

  // compressed mantissa never has the sign bit set
  a_comp_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_req_r.req_type == REQ_COMPRESS) |-> !comp_word[23])
    else $error("compressed mantissa sign set");
`endif

endmodule

>>> rtl/cct_expand.sv
// expansion of a compact word into a 256-bit little-endian target
module cct_expand (
  input  logic [31:0]  compact_in,
  output logic [255:0] expanded
);
  import cct_pkg::*;

  logic [7:0]  expo;
  logic [23:0] mant;
  logic [7:0]  pos_full;
  logic [4:0]  pos;
  logic [23:0] mant_small;

  // split the word into exponent and mantissa
  assign expo = compact_in[31:EXP_SHIFT];
  assign mant = compact_in[23:0] & MANT_MASK;

  // byte position for large exponents, saturated at the cap
  assign pos_full = expo - 8'd3;
  assign pos      = (pos_full > 8'(POS_CAP)) ? 5'(POS_CAP) : pos_full[4:0];

  // small exponents drop low mantissa bytes
  always_comb begin
    case (expo)
      8'd1:    mant_small = mant >> 16;
      8'd2:    mant_small = mant >> 8;
      default: mant_small = mant;
    endcase
  end

  // byte shifter
  always_comb begin
    if ((mant & SIGN_BIT) != 24'd0 || expo == 8'd0) begin
      expanded = '0;
    end else if (expo <= 8'd3) begin
      expanded = {232'd0, mant_small};
    end else begin
      expanded = {232'd0, mant} << {pos, 3'b000};
    end
  end

endmodule

>>> rtl/cct_compress.sv
// compression of a 256-bit target into a compact word
module cct_compress (
  input  logic [255:0] target,
  output logic [31:0]  compact_out
);
  import cct_pkg::*;

  logic [4:0]   top;
  logic         found;
  logic [271:0] ext;
  logic [271:0] window;
  logic [23:0]  mant_raw;
  logic [23:0]  mant;
  logic [7:0]   expo;

  // priority encoder: highest nonzero byte wins
  always_comb begin
    top   = '0;
    found = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (target[8*i +: 8] != 8'd0) begin
        top   = 5'(i);
        found = 1'b1;
      end
    end
  end

  // three bytes from the top down, zeros below byte 0
  assign ext      = {target, 16'd0};
  assign window   = ext >> {top, 3'b000};
  assign mant_raw = window[23:0];

  // keep the sign bit clear by one more byte of shift
  always_comb begin
    if ((mant_raw & SIGN_BIT) != 24'd0) begin
      mant = mant_raw >> 8;
      expo = 8'(top) + 8'd2;
    end else begin
      mant = mant_raw;
      expo = 8'(top) + 8'd1;
    end
  end

  assign compact_out = found ? {expo, mant} : 32'd0;

endmodule

>>> rtl/cct_compare.sv
// unsigned 256-bit test of hash against target
module cct_compare (
  input  logic [255:0] hash,
  input  logic [255:0] target,
  output logic         meets
);

  // at or below the target meets it
  assign meets = (hash <= target);

endmodule
